// File: rtl/core/pdag_pkg.sv
// ----------------------------------------------------------------------------
// pdag_pkg
// Shared widths, register indexes, types and helpers of the dewarp address
// generator.
// ----------------------------------------------------------------------------
package pdag_pkg;

   localparam int FRAC_BITS  = 18;
   localparam int MAX_DIM    = 4096;
   localparam int VEC_N      = 3;
   localparam int VEC_W      = 21;
   localparam int CURVE_W    = 24;
   localparam int DIM_W      = 13;
   localparam int PIX_W      = 12;
   localparam int IDX_W      = 24;
   localparam int RECIP_W    = 32;
   localparam int RECIP_FRAC = 24;
   localparam int CFG_W      = 63;
   localparam int CFG_IDX_W  = 3;

   // datapath widths
   localparam int PROD_W  = VEC_W + CURVE_W;          // base*curve
   localparam int DROW_W  = 32;                       // |down|*row
   localparam int RQ_W    = DROW_W + FRAC_BITS;       // row quotient
   localparam int ACC_W   = 52;
   localparam int C_W     = 35;
   localparam int CMAG_W  = 34;
   localparam int HALF_W  = RECIP_W / 2;
   localparam int MAGP_W  = CMAG_W + HALF_W;
   localparam int SUM_W   = MAGP_W + HALF_W;
   localparam int RR_W    = SUM_W - RECIP_FRAC;
   localparam int DEN_W   = 44;
   localparam int TX_W    = 46;
   localparam int CYW_W   = C_W + DIM_W + 1;
   localparam int HSD_W   = DEN_W + DIM_W + 1;
   localparam int NUM_W   = 60;
   localparam int U_W     = 60;
   localparam int DVS_W   = DEN_W + 1;

   localparam int RDIV_STEPS  = 2;
   localparam int RDIV_STAGES = RQ_W / RDIV_STEPS;
   localparam int PDIV_STAGES = PIX_W + 1;

   localparam logic [CFG_IDX_W-1:0] REG_ORIGIN = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_NORMAL = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_DOWN   = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_RECIP  = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_SRC_W  = 3'd5;
   localparam logic [CFG_IDX_W-1:0] REG_SRC_H  = 3'd6;
   localparam logic [CFG_IDX_W-1:0] REG_DST_H  = 3'd7;

   typedef struct packed {
      logic [PIX_W-1:0]                  col;
      logic [PIX_W-1:0]                  row;
      logic [VEC_N-1:0][ACC_W-1:0]       part;
   } row_side_type;

   typedef struct packed {
      logic [RQ_W-1:0]  num;
      logic [DIM_W-1:0] rem;
      logic             neg;
   } rdiv_lane_type;

   typedef struct packed {
      logic [PIX_W-1:0] col;
      logic [PIX_W-1:0] row;
      logic [DEN_W-1:0] den;
      logic             neg_x;
      logic             neg_y;
      logic             bad;
   } proj_side_type;

   typedef struct packed {
      logic [U_W-1:0]   rem;
      logic [PIX_W-1:0] q;
      logic             ovf;
   } pdiv_lane_type;

   function automatic logic signed [VEC_W-1:0] vec_comp(input logic [CFG_W-1:0] v,
                                                        input logic [1:0] k);
      return v[VEC_W*k +: VEC_W];
   endfunction

   function automatic logic [DIM_W-1:0] clip_dim(input logic [DIM_W-1:0] v);
      return (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
   endfunction

endpackage

// File: rtl/core/perspective_dewarp_address_gen_top.sv
// ----------------------------------------------------------------------------
// perspective_dewarp_address_gen_top
// Source pixel address generator for perspective dewarping, nearest neighbor.
// ----------------------------------------------------------------------------
// One request carries a destination column and row and the column's two curve
// values; one response returns the pixel passed through, the rounded source
// coordinates and the source index, or out_of_range with zeros.
// Configuration goes through csr_wr_en/csr_index/csr_wdata; the user must write it
// only while no request is in flight, as the block itself does not enforce this.
// The dominant parts of the pipeline are the row divider (25 stages of two
// quotient bits each, then a rounding stage) and the projection divider (an
// overflow check, then 12 stages of one quotient bit each).
// Throughput: one request per cycle while the receiver does not stall the response.
// All stages advance together while the response register is empty or being
// taken; req_ready = !rsp_valid || rsp_ready, so a stalled receiver freezes
// the whole pipeline without loss.
// Reset clears all valid bits and loads the register defaults (vectors and
// reciprocal zero, dimensions one).
// ----------------------------------------------------------------------------
module perspective_dewarp_address_gen_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [pdag_pkg::PIX_W-1:0]            req_dst_col,
   input  logic [pdag_pkg::PIX_W-1:0]            req_dst_row,
   input  logic signed [pdag_pkg::CURVE_W-1:0]   req_curve_x,
   input  logic signed [pdag_pkg::CURVE_W-1:0]   req_curve_y,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [pdag_pkg::PIX_W-1:0]            rsp_out_col,
   output logic [pdag_pkg::PIX_W-1:0]            rsp_out_row,
   output logic [pdag_pkg::PIX_W-1:0]            rsp_src_x,
   output logic [pdag_pkg::PIX_W-1:0]            rsp_src_y,
   output logic [pdag_pkg::IDX_W-1:0]            rsp_src_index,
   output logic                                  rsp_out_of_range,
   input  logic                                  csr_wr_en,
   input  logic [pdag_pkg::CFG_IDX_W-1:0]        csr_index,
   input  logic [pdag_pkg::CFG_W-1:0]            csr_wdata
);

   localparam int NL    = pdag_pkg::VEC_N;
   localparam int PW    = pdag_pkg::PIX_W;
   localparam int CW    = pdag_pkg::CURVE_W;
   localparam int VW    = pdag_pkg::VEC_W;
   localparam int DW    = pdag_pkg::DIM_W;
   localparam int FB    = pdag_pkg::FRAC_BITS;
   localparam int PRW   = pdag_pkg::PROD_W;
   localparam int DRW   = pdag_pkg::DROW_W;
   localparam int AW    = pdag_pkg::ACC_W;
   localparam int CCW   = pdag_pkg::C_W;
   localparam int CMW   = pdag_pkg::CMAG_W;
   localparam int HW    = pdag_pkg::HALF_W;
   localparam int MPW   = pdag_pkg::MAGP_W;
   localparam int SW    = pdag_pkg::SUM_W;
   localparam int RRW   = pdag_pkg::RR_W;
   localparam int DNW   = pdag_pkg::DEN_W;
   localparam int TXW   = pdag_pkg::TX_W;
   localparam int CYWW  = pdag_pkg::CYW_W;
   localparam int HSDW  = pdag_pkg::HSD_W;
   localparam int NW    = pdag_pkg::NUM_W;
   localparam int UW    = pdag_pkg::U_W;
   localparam int IW    = pdag_pkg::IDX_W;
   localparam int RW    = pdag_pkg::RECIP_W;
   localparam int RF    = pdag_pkg::RECIP_FRAC;

   localparam logic signed [DNW-1:0] DEN_ONE = DNW'(1) << FB;

   // ---------------------------------------------------------------- config
   logic [pdag_pkg::CFG_W-1:0] origin_ff, base_ff, normal_ff, down_ff;
   logic [RW-1:0]              recip_ff;
   logic [DW-1:0]              src_w_ff, src_h_ff, dst_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= '0;
         base_ff   <= '0;
         normal_ff <= '0;
         down_ff   <= '0;
         recip_ff  <= '0;
         src_w_ff  <= DW'(1);
         src_h_ff  <= DW'(1);
         dst_h_ff  <= DW'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            pdag_pkg::REG_ORIGIN: origin_ff <= csr_wdata;
            pdag_pkg::REG_BASE:   base_ff   <= csr_wdata;
            pdag_pkg::REG_NORMAL: normal_ff <= csr_wdata;
            pdag_pkg::REG_DOWN:   down_ff   <= csr_wdata;
            pdag_pkg::REG_RECIP:  recip_ff  <= csr_wdata[RW-1:0];
            pdag_pkg::REG_SRC_W:  src_w_ff  <= csr_wdata[DW-1:0];
            pdag_pkg::REG_SRC_H:  src_h_ff  <= csr_wdata[DW-1:0];
            pdag_pkg::REG_DST_H:  dst_h_ff  <= csr_wdata[DW-1:0];
            default: ;
         endcase
      end
   end

   logic [DW-1:0]          w_dim, hs_dim, hd_dim, hd_clip;
   logic signed [DW:0]     w_sg, hs_sg;
   logic signed [VW-1:0]   o_c [NL];
   logic signed [VW-1:0]   b_c [NL];
   logic signed [VW-1:0]   n_c [NL];
   logic signed [VW-1:0]   d_c [NL];
   logic [VW-1:0]          d_mag [NL];

   always_comb begin
      w_dim   = pdag_pkg::clip_dim(src_w_ff);
      hs_dim  = pdag_pkg::clip_dim(src_h_ff);
      hd_clip = pdag_pkg::clip_dim(dst_h_ff);
      hd_dim  = (hd_clip == '0) ? DW'(1) : hd_clip;
      w_sg    = $signed({1'b0, w_dim});
      hs_sg   = $signed({1'b0, hs_dim});
      for (int k = 0; k < NL; k++) begin
         o_c[k]   = pdag_pkg::vec_comp(origin_ff, 2'(k));
         b_c[k]   = pdag_pkg::vec_comp(base_ff, 2'(k));
         n_c[k]   = pdag_pkg::vec_comp(normal_ff, 2'(k));
         d_c[k]   = pdag_pkg::vec_comp(down_ff, 2'(k));
         d_mag[k] = d_c[k][VW-1] ? VW'(-d_c[k]) : VW'(d_c[k]);
      end
   end

   // ------------------------------------------------------------- pipeline
   logic adv;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // s1: request register
   logic                 v1_ff;
   logic [PW-1:0]        col1_ff, row1_ff;
   logic signed [CW-1:0] cx1_ff, cy1_ff;

   // s2: products
   logic                  v2_ff;
   logic [PW-1:0]         col2_ff, row2_ff;
   logic signed [PRW-1:0] bcx2_in [NL];
   logic signed [PRW-1:0] bcx2_ff [NL];
   logic signed [PRW-1:0] ncy2_in [NL];
   logic signed [PRW-1:0] ncy2_ff [NL];
   logic [DRW-1:0]        drow2_in [NL];
   logic [DRW-1:0]        drow2_ff [NL];
   logic                  dneg2_ff [NL];

   // s3: partial surface sums
   logic                   v3_ff;
   pdag_pkg::row_side_type side3_in, side3_ff;
   logic [DRW-1:0]         drow3_ff [NL];
   logic                   dneg3_ff [NL];

   // row divider output
   logic                   rd_valid;
   logic signed [AW-1:0]   rd_r [NL];
   pdag_pkg::row_side_type rd_side;

   // s4: full sum
   logic                 v4_ff;
   logic [PW-1:0]        col4_ff, row4_ff;
   logic signed [AW-1:0] acc4_in [NL];
   logic signed [AW-1:0] acc4_ff [NL];

   // s5: surface point
   logic                  v5_ff;
   logic [PW-1:0]         col5_ff, row5_ff;
   logic signed [CCW-1:0] c5_in [NL];
   logic signed [CCW-1:0] c5_ff [NL];

   // s6..s9: depth denominator
   logic                  v6_ff, v7_ff, v8_ff, v9_ff;
   logic [PW-1:0]         col6_ff, row6_ff, col7_ff, row7_ff;
   logic [PW-1:0]         col8_ff, row8_ff, col9_ff, row9_ff;
   logic signed [CCW-1:0] cx6_ff, cy6_ff, cx7_ff, cy7_ff, cx8_ff, cy8_ff, cx9_ff, cy9_ff;
   logic [CMW-1:0]        czm6_in, czm6_ff;
   logic                  czn6_ff, czn7_ff, czn8_ff;
   logic [MPW-1:0]        ph7_in, ph7_ff, pl7_in, pl7_ff;
   logic [SW-1:0]         sum8;
   logic [RRW-1:0]        r8_ff;
   logic signed [DNW-1:0] den9_in, den9_ff;

   // s10..s13: projection numerators
   logic                   v10_ff, v11_ff, v12_ff, v13_ff;
   logic [PW-1:0]          col10_ff, row10_ff, col11_ff, row11_ff;
   logic [PW-1:0]          col12_ff, row12_ff;
   logic signed [TXW-1:0]  tx10_in, tx10_ff;
   logic signed [CYWW-1:0] cyw10_in, cyw10_ff;
   logic signed [HSDW-1:0] hsd10_in, hsd10_ff;
   logic signed [DNW-1:0]  den10_ff, den11_ff, den12_ff;
   logic                   bad10_ff, bad11_ff, bad12_ff;
   logic signed [NW-1:0]   nx11_in, nx11_ff, ny11_in, ny11_ff;
   logic [UW-1:0]          ax12_in, ax12_ff, ay12_in, ay12_ff;
   logic                   negx12_ff, negy12_ff;
   logic [UW-1:0]          ux13_ff, uy13_ff;
   pdag_pkg::proj_side_type side13_ff;

   // projection divider output
   logic                    pd_valid;
   logic [PW-1:0]           pd_qx, pd_qy;
   logic                    pd_ovfx, pd_ovfy;
   pdag_pkg::proj_side_type pd_side;

   // s14: response register
   logic          bad14;
   logic [IW-1:0] idx14;
   logic [PW-1:0] col14_ff, row14_ff, sx14_ff, sy14_ff;
   logic [IW-1:0] idx14_ff;
   logic          oor14_ff;

   always_comb begin
      for (int k = 0; k < NL; k++) begin
         bcx2_in[k]  = PRW'(b_c[k]) * PRW'(cx1_ff);
         ncy2_in[k]  = PRW'(n_c[k]) * PRW'(cy1_ff);
         drow2_in[k] = DRW'(d_mag[k]) * DRW'(row1_ff);
      end
      side3_in.col = col2_ff;
      side3_in.row = row2_ff;
      for (int k = 0; k < NL; k++) begin
         side3_in.part[k] = (AW'(o_c[k]) <<< FB) + AW'(bcx2_ff[k]) + AW'(ncy2_ff[k]);
      end
      for (int k = 0; k < NL; k++) begin
         acc4_in[k] = $signed(rd_side.part[k]) + rd_r[k];
         // half away from zero on the 2^F scale
         c5_in[k]   = CCW'((acc4_ff[k] + (acc4_ff[k][AW-1] ? AW'((1 << (FB - 1)) - 1)
                                                           : AW'(1 << (FB - 1)))) >>> FB);
      end
      czm6_in = c5_ff[2][CCW-1] ? CMW'(-c5_ff[2]) : CMW'(c5_ff[2]);
      ph7_in  = MPW'(czm6_ff) * MPW'(recip_ff[RW-1:HW]);
      pl7_in  = MPW'(czm6_ff) * MPW'(recip_ff[HW-1:0]);
      sum8    = {ph7_ff, {HW{1'b0}}} + SW'(pl7_ff) + (SW'(1) << (RF - 1));
      den9_in = czn8_ff ? DEN_ONE - DNW'(r8_ff) : DEN_ONE + DNW'(r8_ff);
      tx10_in  = (TXW'(cx9_ff) <<< 1) + TXW'(den9_ff);
      cyw10_in = CYWW'(cy9_ff) * CYWW'(w_sg);
      hsd10_in = HSDW'(den9_ff) * HSDW'(hs_sg);
      nx11_in  = NW'(tx10_ff) * NW'(w_sg);
      ny11_in  = (NW'(cyw10_ff) <<< 1) + NW'(hsd10_ff);
      ax12_in  = nx11_ff[NW-1] ? UW'(-nx11_ff) : UW'(nx11_ff);
      ay12_in  = ny11_ff[NW-1] ? UW'(-ny11_ff) : UW'(ny11_ff);
   end

   // a negative numerator only survives when it rounds to zero
   always_comb begin
      bad14 = pd_side.bad || pd_ovfx || pd_ovfy
              || (pd_side.neg_x && pd_qx != '0) || (pd_side.neg_y && pd_qy != '0)
              || ({1'b0, pd_qx} >= w_dim) || ({1'b0, pd_qy} >= hs_dim);
      idx14 = IW'(pd_qy) * IW'(w_dim) + IW'(pd_qx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;  v2_ff  <= 1'b0;  v3_ff  <= 1'b0;  v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;  v6_ff  <= 1'b0;  v7_ff  <= 1'b0;  v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;  v10_ff <= 1'b0;  v11_ff <= 1'b0;  v12_ff <= 1'b0;
         v13_ff <= 1'b0;  rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff  <= req_valid;  v2_ff  <= v1_ff;   v3_ff  <= v2_ff;
         v4_ff  <= rd_valid;   v5_ff  <= v4_ff;   v6_ff  <= v5_ff;
         v7_ff  <= v6_ff;      v8_ff  <= v7_ff;   v9_ff  <= v8_ff;
         v10_ff <= v9_ff;      v11_ff <= v10_ff;  v12_ff <= v11_ff;
         v13_ff <= v12_ff;     rsp_valid_ff <= pd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         col1_ff <= req_dst_col;
         row1_ff <= req_dst_row;
         cx1_ff  <= req_curve_x;
         cy1_ff  <= req_curve_y;

         col2_ff  <= col1_ff;
         row2_ff  <= row1_ff;
         bcx2_ff  <= bcx2_in;
         ncy2_ff  <= ncy2_in;
         drow2_ff <= drow2_in;
         for (int k = 0; k < NL; k++) begin
            dneg2_ff[k] <= d_c[k][VW-1];
         end

         side3_ff <= side3_in;
         drow3_ff <= drow2_ff;
         dneg3_ff <= dneg2_ff;

         col4_ff <= rd_side.col;
         row4_ff <= rd_side.row;
         acc4_ff <= acc4_in;

         col5_ff <= col4_ff;
         row5_ff <= row4_ff;
         c5_ff   <= c5_in;

         col6_ff <= col5_ff;  row6_ff <= row5_ff;
         cx6_ff  <= c5_ff[0]; cy6_ff  <= c5_ff[1];
         czm6_ff <= czm6_in;  czn6_ff <= c5_ff[2][CCW-1];

         col7_ff <= col6_ff;  row7_ff <= row6_ff;
         cx7_ff  <= cx6_ff;   cy7_ff  <= cy6_ff;
         ph7_ff  <= ph7_in;   pl7_ff  <= pl7_in;  czn7_ff <= czn6_ff;

         col8_ff <= col7_ff;  row8_ff <= row7_ff;
         cx8_ff  <= cx7_ff;   cy8_ff  <= cy7_ff;
         r8_ff   <= sum8[SW-1:RF];
         czn8_ff <= czn7_ff;

         col9_ff <= col8_ff;  row9_ff <= row8_ff;
         cx9_ff  <= cx8_ff;   cy9_ff  <= cy8_ff;
         den9_ff <= den9_in;

         col10_ff <= col9_ff;  row10_ff <= row9_ff;
         tx10_ff  <= tx10_in;  cyw10_ff <= cyw10_in;  hsd10_ff <= hsd10_in;
         den10_ff <= den9_ff;
         bad10_ff <= den9_ff[DNW-1] || (den9_ff == '0);

         col11_ff <= col10_ff;  row11_ff <= row10_ff;
         nx11_ff  <= nx11_in;   ny11_ff  <= ny11_in;
         den11_ff <= den10_ff;  bad11_ff <= bad10_ff;

         col12_ff  <= col11_ff;  row12_ff  <= row11_ff;
         ax12_ff   <= ax12_in;   ay12_ff   <= ay12_in;
         negx12_ff <= nx11_ff[NW-1];
         negy12_ff <= ny11_ff[NW-1];
         den12_ff  <= den11_ff;  bad12_ff  <= bad11_ff;

         ux13_ff         <= ax12_ff + UW'(den12_ff);
         uy13_ff         <= ay12_ff + UW'(den12_ff);
         side13_ff.col   <= col12_ff;
         side13_ff.row   <= row12_ff;
         side13_ff.den   <= den12_ff;
         side13_ff.neg_x <= negx12_ff;
         side13_ff.neg_y <= negy12_ff;
         side13_ff.bad   <= bad12_ff;

         col14_ff <= pd_side.col;
         row14_ff <= pd_side.row;
         sx14_ff  <= bad14 ? '0 : pd_qx;
         sy14_ff  <= bad14 ? '0 : pd_qy;
         idx14_ff <= bad14 ? '0 : idx14;
         oor14_ff <= bad14;
      end
   end

   pdag_row_div u_row_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v3_ff),
      .divisor   (hd_dim),
      .in_mag    (drow3_ff),
      .in_neg    (dneg3_ff),
      .in_side   (side3_ff),
      .out_valid (rd_valid),
      .out_r     (rd_r),
      .out_side  (rd_side)
   );

   pdag_proj_div u_proj_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v13_ff),
      .in_u_x    (ux13_ff),
      .in_u_y    (uy13_ff),
      .in_side   (side13_ff),
      .out_valid (pd_valid),
      .out_q_x   (pd_qx),
      .out_q_y   (pd_qy),
      .out_ovf_x (pd_ovfx),
      .out_ovf_y (pd_ovfy),
      .out_side  (pd_side)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_col      = col14_ff;
   assign rsp_out_row      = row14_ff;
   assign rsp_src_x        = sx14_ff;
   assign rsp_src_y        = sy14_ff;
   assign rsp_src_index    = idx14_ff;
   assign rsp_out_of_range = oor14_ff;

endmodule

// File: rtl/core/pdag_row_div.sv
// ----------------------------------------------------------------------------
// pdag_row_div
// Pipelined restoring divider, three lanes sharing one divisor: rounds
// |n|*2^F / d half away from zero and restores the sign.
// ----------------------------------------------------------------------------
module pdag_row_div (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     en,
   input  logic                                     in_valid,
   input  logic [pdag_pkg::DIM_W-1:0]               divisor,
   input  logic [pdag_pkg::DROW_W-1:0]              in_mag [pdag_pkg::VEC_N],
   input  logic                                     in_neg [pdag_pkg::VEC_N],
   input  pdag_pkg::row_side_type                   in_side,
   output logic                                     out_valid,
   output logic signed [pdag_pkg::ACC_W-1:0]        out_r [pdag_pkg::VEC_N],
   output pdag_pkg::row_side_type                   out_side
);

   localparam int NS = pdag_pkg::RDIV_STAGES;
   localparam int NL = pdag_pkg::VEC_N;
   localparam int DW = pdag_pkg::DIM_W;
   localparam int QW = pdag_pkg::RQ_W;
   localparam int AW = pdag_pkg::ACC_W;

   function automatic pdag_pkg::rdiv_lane_type div_steps(input pdag_pkg::rdiv_lane_type a,
                                                         input logic [DW-1:0] d);
      pdag_pkg::rdiv_lane_type r;
      logic [DW:0]             t;
      r = a;
      for (int i = 0; i < pdag_pkg::RDIV_STEPS; i++) begin
         t = {r.rem, r.num[QW-1]};
         if (t >= {1'b0, d}) begin
            t     = t - {1'b0, d};
            r.num = {r.num[QW-2:0], 1'b1};
         end else begin
            r.num = {r.num[QW-2:0], 1'b0};
         end
         r.rem = t[DW-1:0];
      end
      return r;
   endfunction

   pdag_pkg::rdiv_lane_type lane_in [NS][NL];
   pdag_pkg::rdiv_lane_type lane_ff [NS][NL];
   pdag_pkg::row_side_type  side_ff [NS];
   logic [NS-1:0]           vld_ff;

   logic                    out_valid_ff;
   logic signed [AW-1:0]    out_r_in  [NL];
   logic signed [AW-1:0]    out_r_ff  [NL];
   pdag_pkg::row_side_type  out_side_ff;

   always_comb begin
      pdag_pkg::rdiv_lane_type first;
      for (int l = 0; l < NL; l++) begin
         first.num = {in_mag[l], {pdag_pkg::FRAC_BITS{1'b0}}};
         first.rem = '0;
         first.neg = in_neg[l];
         lane_in[0][l] = div_steps(first, divisor);
         for (int s = 1; s < NS; s++) begin
            lane_in[s][l] = div_steps(lane_ff[s-1][l], divisor);
         end
      end
   end

   // round up when the remainder reaches half the divisor
   always_comb begin
      logic [AW-1:0] q;
      logic          up;
      for (int l = 0; l < NL; l++) begin
         up = ({lane_ff[NS-1][l].rem, 1'b0} >= {1'b0, divisor});
         q  = AW'(lane_ff[NS-1][l].num) + AW'(up);
         out_r_in[l] = lane_ff[NS-1][l].neg ? -$signed(q) : $signed(q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[NS-2:0], in_valid};
         out_valid_ff <= vld_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff     <= lane_in;
         side_ff[0]  <= in_side;
         for (int s = 1; s < NS; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
         out_r_ff    <= out_r_in;
         out_side_ff <= side_ff[NS-1];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_r     = out_r_ff;
   assign out_side  = out_side_ff;

endmodule

// File: rtl/core/pdag_proj_div.sv
// ----------------------------------------------------------------------------
// pdag_proj_div
// Pipelined restoring divider for the projection: two lanes, one divisor,
// an overflow check followed by one quotient bit per stage.
// ----------------------------------------------------------------------------
module pdag_proj_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic [pdag_pkg::U_W-1:0]         in_u_x,
   input  logic [pdag_pkg::U_W-1:0]         in_u_y,
   input  pdag_pkg::proj_side_type          in_side,
   output logic                             out_valid,
   output logic [pdag_pkg::PIX_W-1:0]       out_q_x,
   output logic [pdag_pkg::PIX_W-1:0]       out_q_y,
   output logic                             out_ovf_x,
   output logic                             out_ovf_y,
   output pdag_pkg::proj_side_type          out_side
);

   localparam int NS = pdag_pkg::PDIV_STAGES;
   localparam int UW = pdag_pkg::U_W;
   localparam int PW = pdag_pkg::PIX_W;

   pdag_pkg::pdiv_lane_type x_in [NS];
   pdag_pkg::pdiv_lane_type x_ff [NS];
   pdag_pkg::pdiv_lane_type y_in [NS];
   pdag_pkg::pdiv_lane_type y_ff [NS];
   pdag_pkg::proj_side_type side_ff [NS];
   logic [NS-1:0]           vld_ff;

   function automatic pdag_pkg::pdiv_lane_type start(input logic [UW-1:0] u,
                                                     input logic [UW-1:0] dvs);
      pdag_pkg::pdiv_lane_type r;
      r.rem = u;
      r.q   = '0;
      r.ovf = (u >= (dvs << PW));
      return r;
   endfunction

   function automatic pdag_pkg::pdiv_lane_type step(input pdag_pkg::pdiv_lane_type a,
                                                    input logic [UW-1:0] dvs,
                                                    input int sh);
      pdag_pkg::pdiv_lane_type r;
      logic [UW-1:0]           t;
      r = a;
      t = dvs << sh;
      if (a.rem >= t) begin
         r.rem = a.rem - t;
         r.q   = a.q | (PW'(1) << sh);
      end
      return r;
   endfunction

   always_comb begin
      x_in[0] = start(in_u_x, UW'({in_side.den, 1'b0}));
      y_in[0] = start(in_u_y, UW'({in_side.den, 1'b0}));
      for (int s = 1; s < NS; s++) begin
         x_in[s] = step(x_ff[s-1], UW'({side_ff[s-1].den, 1'b0}), PW - s);
         y_in[s] = step(y_ff[s-1], UW'({side_ff[s-1].den, 1'b0}), PW - s);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff       <= x_in;
         y_ff       <= y_in;
         side_ff[0] <= in_side;
         for (int s = 1; s < NS; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign out_q_x   = x_ff[NS-1].q;
   assign out_q_y   = y_ff[NS-1].q;
   assign out_ovf_x = x_ff[NS-1].ovf;
   assign out_ovf_y = y_ff[NS-1].ovf;
   assign out_side  = side_ff[NS-1];

endmodule

// File: rtl/core/pdag_checker.sv
// ----------------------------------------------------------------------------
// pdag_checker
// Port-level checks of the dewarp address generator, bound to the top level.
// ----------------------------------------------------------------------------
module pdag_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [pdag_pkg::PIX_W-1:0]        rsp_out_col,
   input logic [pdag_pkg::PIX_W-1:0]        rsp_out_row,
   input logic [pdag_pkg::PIX_W-1:0]        rsp_src_x,
   input logic [pdag_pkg::PIX_W-1:0]        rsp_src_y,
   input logic [pdag_pkg::IDX_W-1:0]        rsp_src_index,
   input logic                              rsp_out_of_range
);

   // a stalled response holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_col) && $stable(rsp_out_row)
         && $stable(rsp_src_x) && $stable(rsp_src_y) && $stable(rsp_src_index)
         && $stable(rsp_out_of_range))
      else $error("response changed while stalled");

   // rejected points carry zero coordinates and index
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_src_x == '0 && rsp_src_y == '0
         && rsp_src_index == '0)
      else $error("out-of-range response with nonzero address");

   // request side only waits on a full, stalled response register
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow response stall");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind perspective_dewarp_address_gen_top pdag_checker u_pdag_checker (.*);

// File: dv/tb_perspective_dewarp_address_gen_top.sv
// ----------------------------------------------------------------------------
// tb_perspective_dewarp_address_gen_top
// Self-checking testbench of the perspective dewarp address generator.
// ----------------------------------------------------------------------------
// A directed table runs first: register defaults, extreme fields, clipped and
// zero dimensions, non-positive denominators. Random register settings and
// random requests follow. Each response is checked field by field against a
// bit-exact fixed-point predictor in the bench. Both handshakes idle at
// random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_perspective_dewarp_address_gen_top;
   import pdag_pkg::*;

   localparam int LATENCY    = 60;
   localparam int CYCLE_CAP  = 600000;
   localparam int RAND_SETS  = 5;
   localparam int SET_ITEMS  = 100;
   localparam int V_MAX      = (1 << 20) - 1;
   localparam int V_MIN      = -(1 << 20);
   localparam int C_MAX      = 8388607;
   localparam int C_MIN      = -8388608;
   localparam int UNIT       = 1 << FRAC_BITS;

   typedef logic signed [127:0] wide_t;

   typedef struct packed {
      logic [PIX_W-1:0] col;
      logic [PIX_W-1:0] row;
      logic [PIX_W-1:0] sx;
      logic [PIX_W-1:0] sy;
      logic [IDX_W-1:0] idx;
      logic             oor;
   } pix_rsp_t;

   typedef struct {
      int   setting;
      int   col;
      int   row;
      int   cx;
      int   cy;
      bit   known_oor;
   } dir_row_t;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [PIX_W-1:0]          req_dst_col;
   logic [PIX_W-1:0]          req_dst_row;
   logic signed [CURVE_W-1:0] req_curve_x;
   logic signed [CURVE_W-1:0] req_curve_y;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [PIX_W-1:0]          rsp_out_col;
   logic [PIX_W-1:0]          rsp_out_row;
   logic [PIX_W-1:0]          rsp_src_x;
   logic [PIX_W-1:0]          rsp_src_y;
   logic [IDX_W-1:0]          rsp_src_index;
   logic                      rsp_out_of_range;
   logic                      csr_wr_en;
   logic [CFG_IDX_W-1:0]      csr_index;
   logic [CFG_W-1:0]          csr_wdata;

   // sideband that travels with the request: response is known to be out of range
   logic                      req_known_oor;
   logic                      hold_req;
   logic                      sink_calm;
   logic                      src_calm;

   logic [CFG_W-1:0] cfg_shadow [8];
   pix_rsp_t         addr_q [$];
   int               errors;
   int               n_req;
   int               n_rsp;
   int               n_oor;
   int               cycles;
   int               hold_left;
   int               stall_left;
   bit               hold_done;

   perspective_dewarp_address_gen_top u_top (.*);

   always #2 clock = ~clock;

   // ---------------------------------------------------------------- predictor
   function automatic wide_t div_rnd(wide_t n, wide_t d);
      wide_t m;
      wide_t q;
      m = (n < 0) ? -n : n;
      q = (m + (d >>> 1)) / d;
      return (n < 0) ? -q : q;
   endfunction

   function automatic wide_t vcomp(logic [CFG_W-1:0] v, int k);
      logic signed [VEC_W-1:0] s;
      s = v[VEC_W*k +: VEC_W];
      return wide_t'(s);
   endfunction

   function automatic wide_t dim_of(logic [CFG_W-1:0] v);
      logic [DIM_W-1:0] d;
      d = v[DIM_W-1:0];
      return (d > 13'd4096) ? wide_t'(4096) : wide_t'(d);
   endfunction

   function automatic pix_rsp_t predict_src_addr(logic [PIX_W-1:0] col,
                                                 logic [PIX_W-1:0] row,
                                                 logic signed [CURVE_W-1:0] cx,
                                                 logic signed [CURVE_W-1:0] cy);
      pix_rsp_t r;
      wide_t    one, w, hs, hd, acc, den, mq, sx, sy, ix, rcp;
      wide_t    c [3];
      bit       bad;
      one = wide_t'(1) <<< FRAC_BITS;
      w   = dim_of(cfg_shadow[REG_SRC_W]);
      hs  = dim_of(cfg_shadow[REG_SRC_H]);
      hd  = dim_of(cfg_shadow[REG_DST_H]);
      rcp = wide_t'(cfg_shadow[REG_RECIP][RECIP_W-1:0]);
      if (hd == 0) hd = 1;
      for (int k = 0; k < 3; k++) begin
         acc = vcomp(cfg_shadow[REG_ORIGIN], k) * one
             + vcomp(cfg_shadow[REG_BASE], k) * wide_t'(cx)
             + vcomp(cfg_shadow[REG_NORMAL], k) * wide_t'(cy)
             + div_rnd(vcomp(cfg_shadow[REG_DOWN], k) * wide_t'(row) * one, hd);
         c[k] = div_rnd(acc, one);
      end
      mq  = (((c[2] < 0) ? -c[2] : c[2]) * rcp + (wide_t'(1) <<< 23)) >>> RECIP_FRAC;
      den = one + ((c[2] < 0) ? -mq : mq);
      bad = (den <= 0);
      sx  = 0;
      sy  = 0;
      if (!bad) begin
         sx  = div_rnd(2 * c[0] * w + den * w, 2 * den);
         sy  = div_rnd(2 * c[1] * w + hs * den, 2 * den);
         bad = sx < 0 || sy < 0 || sx >= w || sy >= hs || sx > 4095 || sy > 4095;
      end
      r.col = col;
      r.row = row;
      if (bad) begin
         r.sx  = '0;
         r.sy  = '0;
         r.idx = '0;
         r.oor = 1'b1;
      end else begin
         ix    = sy * w + sx;
         r.sx  = sx[PIX_W-1:0];
         r.sy  = sy[PIX_W-1:0];
         r.idx = ix[IDX_W-1:0];
         r.oor = 1'b0;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- checking
   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
      errors++;
   endtask

   always @(posedge clock) begin
      pix_rsp_t e;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (req_known_oor)
               e = '{req_dst_col, req_dst_row, '0, '0, '0, 1'b1};
            else
               e = predict_src_addr(req_dst_col, req_dst_row, req_curve_x, req_curve_y);
            addr_q.push_back(e);
            n_req++;
         end
         if (rsp_valid && rsp_ready) begin
            n_rsp++;
            if (rsp_out_of_range) n_oor++;
            if (addr_q.size() == 0) begin
               report_mismatch("response with nothing pending", rsp_out_col, 0);
            end else begin
               e = addr_q.pop_front();
               if (rsp_out_col !== e.col) report_mismatch("out_col", rsp_out_col, e.col);
               if (rsp_out_row !== e.row) report_mismatch("out_row", rsp_out_row, e.row);
               if (rsp_src_x !== e.sx) report_mismatch("src_x", rsp_src_x, e.sx);
               if (rsp_src_y !== e.sy) report_mismatch("src_y", rsp_src_y, e.sy);
               if (rsp_src_index !== e.idx)
                  report_mismatch("src_index", rsp_src_index, e.idx);
               if (rsp_out_of_range !== e.oor)
                  report_mismatch("out_of_range", rsp_out_of_range, e.oor);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("TIMEOUT after %0d cycles, %0d requests pending", cycles, addr_q.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (hold_req && !hold_done) begin
         hold_done = 1;
         hold_left = 300;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (sink_calm) begin
         rsp_ready <= 1'b1;
      end else begin
         int r;
         r = $urandom_range(0, 99);
         if (r < 60) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            stall_left = (r < 93) ? $urandom_range(0, 3) : $urandom_range(15, 50);
         end
      end
   end

   // ---------------------------------------------------------------- sender
   function automatic int rnd_s(int lo, int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic logic [CFG_W-1:0] pack3(int x, int y, int z);
      return {z[VEC_W-1:0], y[VEC_W-1:0], x[VEC_W-1:0]};
   endfunction

   task automatic csr_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      cfg_shadow[idx] = data;
      @(posedge clock);
   endtask

   task automatic drain();
      while (addr_q.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic apply_setting(int id);
      drain();
      case (id)
         1: begin
            csr_write(REG_ORIGIN, pack3(-131072, -104858, 0));
            csr_write(REG_BASE, pack3(26214, 0, 0));
            csr_write(REG_NORMAL, pack3(0, 0, 26214));
            csr_write(REG_DOWN, pack3(0, 209715, 0));
            csr_write(REG_RECIP, 63'(1 << 22));
            csr_write(REG_SRC_W, 63'd640);
            csr_write(REG_SRC_H, 63'd480);
            csr_write(REG_DST_H, 63'd512);
         end
         2: begin
            // extremes; dimension above the limit clips, zero dst height acts as one
            csr_write(REG_ORIGIN, pack3(V_MAX, V_MIN, V_MAX));
            csr_write(REG_BASE, pack3(V_MIN, V_MAX, V_MIN));
            csr_write(REG_NORMAL, pack3(V_MAX, V_MAX, V_MIN));
            csr_write(REG_DOWN, pack3(V_MIN, V_MIN, V_MAX));
            csr_write(REG_RECIP, 63'hFFFF_FFFF);
            csr_write(REG_SRC_W, 63'd8191);
            csr_write(REG_SRC_H, 63'd4096);
            csr_write(REG_DST_H, 63'd0);
         end
         3: begin
            // zero source size: nothing can be sampled
            csr_write(REG_ORIGIN, pack3(0, 0, 0));
            csr_write(REG_RECIP, 63'd0);
            csr_write(REG_SRC_W, 63'd0);
            csr_write(REG_SRC_H, 63'd0);
            csr_write(REG_DST_H, 63'd1);
         end
         default: ;
      endcase
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_setting();
      int kind;
      kind = $urandom_range(0, 3);
      drain();
      if (kind == 1) begin
         for (int i = 0; i < 5; i++)
            csr_write(CFG_IDX_W'(i), {$urandom, $urandom});
         csr_write(REG_SRC_W, 63'($urandom_range(0, 8191)));
         csr_write(REG_SRC_H, 63'($urandom_range(0, 8191)));
         csr_write(REG_DST_H, 63'($urandom_range(0, 8191)));
      end else begin
         csr_write(REG_ORIGIN, pack3(rnd_s(-160000, -100000), rnd_s(-160000, 100000),
                                     rnd_s(-30000, 30000)));
         csr_write(REG_BASE, pack3(rnd_s(-80000, 80000), rnd_s(-20000, 20000),
                                   rnd_s(-20000, 20000)));
         csr_write(REG_NORMAL, pack3(rnd_s(-20000, 20000), rnd_s(-20000, 20000),
                                     rnd_s(-80000, 80000)));
         csr_write(REG_DOWN, pack3(rnd_s(-20000, 20000), rnd_s(-300000, 300000),
                                   rnd_s(-50000, 50000)));
         csr_write(REG_RECIP, 63'($urandom_range(0, 1 << 24)));
         case (kind)
            2: begin
               csr_write(REG_SRC_W, 63'($urandom_range(1, 16)));
               csr_write(REG_SRC_H, 63'($urandom_range(1, 16)));
               csr_write(REG_DST_H, 63'($urandom_range(1, 16)));
            end
            3: begin
               csr_write(REG_SRC_W, 63'd4096);
               csr_write(REG_SRC_H, 63'd4096);
               csr_write(REG_DST_H, 63'd4096);
            end
            default: begin
               csr_write(REG_SRC_W, 63'($urandom_range(1, 4096)));
               csr_write(REG_SRC_H, 63'($urandom_range(1, 4096)));
               csr_write(REG_DST_H, 63'($urandom_range(1, 4096)));
            end
         endcase
      end
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_pixel(int col, int row, int cx, int cy, bit known_oor);
      int r;
      r = src_calm ? 0 : $urandom_range(0, 99);
      if (r >= 55) begin
         req_valid <= 1'b0;
         repeat ((r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_dst_col   <= col[PIX_W-1:0];
      req_dst_row   <= row[PIX_W-1:0];
      req_curve_x   <= cx[CURVE_W-1:0];
      req_curve_y   <= cy[CURVE_W-1:0];
      req_known_oor <= known_oor;
      do @(posedge clock); while (!req_ready);
   endtask

   dir_row_t dir_tab [] = '{
      '{0, 0, 0, 0, 0, 1},
      '{0, 4095, 4095, C_MAX, C_MAX, 1},
      '{0, 0, 4095, C_MIN, C_MIN, 1},
      '{0, 4095, 0, C_MAX, C_MIN, 1},
      '{1, 320, 0, 0, 0, 0},
      '{1, 100, 511, UNIT, UNIT, 0},
      '{1, 639, 256, -UNIT, 4 * UNIT, 0},
      '{1, 1, 1, 10 * UNIT, -10 * UNIT, 0},
      '{1, 2, 100, C_MAX, C_MIN, 0},
      '{1, 3, 4095, C_MIN, C_MAX, 0},
      '{1, 4095, 300, UNIT / 2, 0, 0},
      '{2, 0, 0, 0, 0, 0},
      '{2, 4095, 4095, C_MAX, C_MAX, 0},
      '{2, 4095, 4095, C_MIN, C_MIN, 0},
      '{2, 7, 4095, C_MIN, C_MAX, 0},
      '{2, 8, 0, C_MAX, C_MIN, 0},
      '{3, 5, 5, 0, 0, 1},
      '{3, 4095, 4095, C_MAX, C_MIN, 1}
   };

   initial begin
      int cur;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_dst_col   <= '0;
      req_dst_row   <= '0;
      req_curve_x   <= '0;
      req_curve_y   <= '0;
      req_known_oor <= 1'b0;
      csr_wr_en     <= 1'b0;
      csr_index     <= '0;
      csr_wdata     <= '0;
      hold_req      <= 1'b0;
      sink_calm     <= 1'b0;
      src_calm      <= 1'b0;
      for (int i = 0; i < 8; i++) cfg_shadow[i] = (i >= REG_SRC_W) ? 63'd1 : 63'd0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      cur = 0;
      foreach (dir_tab[i]) begin
         if (dir_tab[i].setting != cur) begin
            req_valid <= 1'b0;
            apply_setting(dir_tab[i].setting);
            cur = dir_tab[i].setting;
         end
         send_pixel(dir_tab[i].col, dir_tab[i].row, dir_tab[i].cx, dir_tab[i].cy,
                    dir_tab[i].known_oor);
      end

      for (int s = 0; s < RAND_SETS; s++) begin
         req_valid <= 1'b0;
         random_setting();
         // one set runs without any idling; the first one also sees the long hold-off
         src_calm  <= (s == 2);
         sink_calm <= (s == 2);
         if (s == 0) hold_req <= 1'b1;
         for (int i = 0; i < SET_ITEMS; i++) begin
            if ($urandom_range(0, 99) < 85)
               send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095),
                          rnd_s(-(2 * UNIT), 2 * UNIT), rnd_s(-UNIT, UNIT), 0);
            else
               send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095),
                          int'($urandom), int'($urandom), 0);
         end
      end
      req_valid <= 1'b0;
      drain();

      $display("Covered %0d requests over directed and %0d random settings", n_req, RAND_SETS);
      $display("%0d responses checked, %0d of them out of range", n_rsp, n_oor);
      if (errors == 0 && addr_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// File: files.f
rtl/core/pdag_pkg.sv
rtl/core/pdag_row_div.sv
rtl/core/pdag_proj_div.sv
rtl/core/perspective_dewarp_address_gen_top.sv
rtl/core/pdag_checker.sv
dv/tb_perspective_dewarp_address_gen_top.sv
